// ===== design/rrts_pkg.sv =====
// types and constants shared by the round-robin thread scheduler
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int QuantaW = 32;
  localparam int TidW    = 4;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_SPAWN  = 3'd1,
    OP_TERM   = 3'd2,
    OP_BLOCK  = 3'd3,
    OP_RESUME = 3'd4,
    OP_SLEEP  = 3'd5,
    OP_TICK   = 3'd6,
    OP_QUERY  = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NO_THREAD  = 3'd1,
    STS_MAIN       = 3'd2,
    STS_FULL       = 3'd3,
    STS_NULL_ENTRY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_UNUSED  = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_BLOCKED = 2'd3
  } slot_state_e;

  typedef struct packed {
    slot_state_e          state;
    logic [QuantaW-1:0]   quanta;
  } slot_entry_t;

  typedef struct packed {
    opcode_e              opcode;
    logic [TidW-1:0]      thread_id;
    logic                 entry_present;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [QuantaW-1:0]   result_value;
    logic [TidW-1:0]      running_thread;
    logic [QuantaW-1:0]   tick_total;
    logic                 switched;
    logic                 process_end;
  } out_item_t;

endpackage

// ===== design/round_robin_thread_scheduler.sv =====
// round-robin thread scheduler: event sequencer around the slot table memory
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (opcode, thread_id, entry_present)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (status ... process_end)
//
// one event at a time; init and early errors go straight to the finish step, single-slot events
// read one slot first, and spawn, tick and terminate of the current slot walk the table one slot
// per cycle through the single memory read port.
// reset is immediate: per-slot valid bits stand in for the table contents.
// a finished result waits in the output register while the next event runs.
`timescale 1ns / 1ps

module round_robin_thread_scheduler #(
  parameter int THREAD_SLOTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rrts_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rrts_pkg::out_item_t   out_item_o
);
  import rrts_pkg::*;

  localparam int                SlotW  = $clog2(THREAD_SLOTS);
  localparam logic [SlotW:0]    NSlots = (SlotW+1)'(THREAD_SLOTS);
  localparam logic [SlotW-1:0]  LastOff = SlotW'(THREAD_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE2,
    ST_FIN
  } state_e;

  state_e             state_q, state_d;
  opcode_e            op_q, op_d;
  logic [SlotW-1:0]   tid_q, tid_d;
  logic [SlotW-1:0]   cur_q, cur_d;
  logic [SlotW-1:0]   before_q, before_d;
  logic [QuantaW-1:0] total_q, total_d;
  slot_entry_t        ent_q, ent_d;
  status_e            sts_q, sts_d;
  logic [QuantaW-1:0] val_q, val_d;
  logic               end_q, end_d;
  logic [SlotW-1:0]   base_q, base_d;
  logic [SlotW-1:0]   off_q, off_d;
  logic               iss_q, iss_d;
  logic               pend_q, pend_d;
  logic               last_q, last_d;
  logic [SlotW-1:0]   pend_addr_q, pend_addr_d;
  logic [SlotW-1:0]   hit_q, hit_d;
  slot_entry_t        hit_ent_q, hit_ent_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               mem_rd_en;
  logic [SlotW-1:0]   mem_rd_addr;
  slot_entry_t        mem_rd_ent;
  logic               mem_wr_en;
  logic [SlotW-1:0]   mem_wr_addr;
  slot_entry_t        mem_wr_ent;
  logic               mem_clr;
  logic               mem_clr_boot;

  logic [SlotW:0]     scan_sum;
  logic [SlotW-1:0]   scan_addr;
  logic               scan_match;
  logic               tid_in_range;
  logic               out_free;

  rrts_slot_mem #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (mem_rd_en),
    .rd_addr_i  (mem_rd_addr),
    .rd_ent_o   (mem_rd_ent),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (mem_wr_addr),
    .wr_ent_i   (mem_wr_ent),
    .clr_i      (mem_clr),
    .clr_boot_i (mem_clr_boot)
  );

  // round-robin walk address, wrapped at the slot count
  assign scan_sum  = {1'b0, base_q} + {1'b0, off_q};
  assign scan_addr = (scan_sum >= NSlots) ? SlotW'(scan_sum - NSlots) : SlotW'(scan_sum);
  assign scan_match = (op_q == OP_SPAWN) ? (mem_rd_ent.state == SLOT_UNUSED)
                                         : (mem_rd_ent.state == SLOT_READY);
  assign tid_in_range = (32'(in_item_i.thread_id) < THREAD_SLOTS);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tid_d       = tid_q;
    cur_d       = cur_q;
    before_d    = before_q;
    total_d     = total_q;
    ent_d       = ent_q;
    sts_d       = sts_q;
    val_d       = val_q;
    end_d       = end_q;
    base_d      = base_q;
    off_d       = off_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    last_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    hit_d       = hit_q;
    hit_ent_d   = hit_ent_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    mem_rd_en    = 1'b0;
    mem_rd_addr  = tid_q;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = tid_q;
    mem_wr_ent   = ent_q;
    mem_clr      = 1'b0;
    mem_clr_boot = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.opcode;
          tid_d    = SlotW'(in_item_i.thread_id);
          before_d = cur_q;
          sts_d    = STS_OK;
          val_d    = '0;
          end_d    = 1'b0;
          state_d  = ST_FIN;
          case (in_item_i.opcode)
            OP_INIT: begin
              mem_clr      = 1'b1;
              mem_clr_boot = 1'b1;
              cur_d        = '0;
              total_d      = QuantaW'(1);
            end
            OP_SPAWN: begin
              if (!in_item_i.entry_present) begin
                sts_d = STS_NULL_ENTRY;
              end else begin
                base_d  = '0;
                off_d   = '0;
                iss_d   = 1'b1;
                state_d = ST_SCAN;
              end
            end
            OP_SLEEP: begin
              if (cur_q == '0) begin
                sts_d = STS_MAIN;
              end else begin
                tid_d       = cur_q;
                mem_rd_en   = 1'b1;
                mem_rd_addr = cur_q;
                state_d     = ST_READ;
              end
            end
            OP_TICK: begin
              total_d     = total_q + QuantaW'(1);
              tid_d       = cur_q;
              mem_rd_en   = 1'b1;
              mem_rd_addr = cur_q;
              state_d     = ST_READ;
            end
            default: begin
              if (!tid_in_range) begin
                sts_d = STS_NO_THREAD;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = SlotW'(in_item_i.thread_id);
                state_d     = ST_READ;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        ent_d   = mem_rd_ent;
        state_d = ST_FIN;
        if (op_q == OP_TICK) begin
          ent_d.quanta = mem_rd_ent.quanta + QuantaW'(1);
          base_d  = cur_q;
          off_d   = SlotW'(1);
          iss_d   = 1'b1;
          state_d = ST_SCAN;
        end else if (mem_rd_ent.state == SLOT_UNUSED) begin
          sts_d = STS_NO_THREAD;
        end else begin
          case (op_q)
            OP_TERM: begin
              if (tid_q == '0) begin
                mem_clr = 1'b1;
                cur_d   = '0;
                end_d   = 1'b1;
              end else begin
                mem_wr_en  = 1'b1;
                mem_wr_ent = '{state: SLOT_UNUSED, quanta: '0};
                if (tid_q == cur_q) begin
                  base_d  = cur_q;
                  off_d   = SlotW'(1);
                  iss_d   = 1'b1;
                  state_d = ST_SCAN;
                end
              end
            end
            OP_BLOCK: begin
              if (tid_q == '0) begin
                sts_d = STS_MAIN;
              end else begin
                mem_wr_en  = 1'b1;
                mem_wr_ent = '{state: SLOT_BLOCKED, quanta: mem_rd_ent.quanta};
              end
            end
            OP_RESUME: begin
              if (mem_rd_ent.state == SLOT_BLOCKED) begin
                mem_wr_en  = 1'b1;
                mem_wr_ent = '{state: SLOT_READY, quanta: mem_rd_ent.quanta};
              end
            end
            OP_SLEEP: begin
              mem_wr_en  = 1'b1;
              mem_wr_ent = '{state: SLOT_BLOCKED, quanta: mem_rd_ent.quanta};
            end
            OP_QUERY: begin
              val_d = mem_rd_ent.quanta
                    + QuantaW'(mem_rd_ent.state == SLOT_RUNNING);
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, check the one issued in the cycle before
        if (iss_q) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = scan_addr;
          pend_d      = 1'b1;
          last_d      = (off_q == LastOff);
          pend_addr_d = scan_addr;
          off_d       = off_q + SlotW'(1);
          iss_d       = (off_q != LastOff);
        end
        if (pend_q && scan_match) begin
          iss_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_FIN;
          case (op_q)
            OP_SPAWN: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = pend_addr_q;
              mem_wr_ent  = '{state: SLOT_READY, quanta: '0};
              val_d       = QuantaW'(pend_addr_q);
            end
            OP_TICK: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = cur_q;
              mem_wr_ent  = ent_q;
              if (ent_q.state == SLOT_RUNNING) begin
                mem_wr_ent.state = SLOT_READY;
              end
              hit_d     = pend_addr_q;
              hit_ent_d = mem_rd_ent;
              state_d   = ST_WRITE2;
            end
            default: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = pend_addr_q;
              mem_wr_ent  = '{state: SLOT_RUNNING, quanta: mem_rd_ent.quanta};
              cur_d       = pend_addr_q;
            end
          endcase
        end else if (pend_q && last_q) begin
          iss_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_FIN;
          if (op_q == OP_SPAWN) begin
            sts_d = STS_FULL;
          end else if (op_q == OP_TICK) begin
            // nobody else ready: current slot keeps its state
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_q;
            mem_wr_ent  = ent_q;
          end
        end
      end

      ST_WRITE2: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = hit_q;
        mem_wr_ent  = '{state: SLOT_RUNNING, quanta: hit_ent_q.quanta};
        cur_d       = hit_q;
        state_d     = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          out_d.status         = sts_q;
          out_d.result_value   = val_q;
          out_d.running_thread = TidW'(cur_q);
          out_d.tick_total     = total_q;
          out_d.switched       = (cur_q != before_q);
          out_d.process_end    = end_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      total_q     <= QuantaW'(1);
      iss_q       <= 1'b0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      total_q     <= total_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    tid_q       <= tid_d;
    before_q    <= before_d;
    ent_q       <= ent_d;
    sts_q       <= sts_d;
    val_q       <= val_d;
    end_q       <= end_d;
    base_q      <= base_d;
    off_q       <= off_d;
    pend_addr_q <= pend_addr_d;
    hit_q       <= hit_d;
    hit_ent_q   <= hit_ent_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start processing");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result loaded outside the finish step");

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < THREAD_SLOTS)
    else $error("current slot beyond the table");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_wr_en)
    else $error("slot table written while idle");
`endif

endmodule

// ===== design/rrts_slot_mem.sv =====
// slot table memory with per-slot valid bits and reset defaults
`timescale 1ns / 1ps

module rrts_slot_mem #(
  parameter int THREAD_SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(THREAD_SLOTS)-1:0]   rd_addr_i,
  output rrts_pkg::slot_entry_t             rd_ent_o,
  input  logic                              wr_en_i,
  input  logic [$clog2(THREAD_SLOTS)-1:0]   wr_addr_i,
  input  rrts_pkg::slot_entry_t             wr_ent_i,
  input  logic                              clr_i,
  input  logic                              clr_boot_i
);
  import rrts_pkg::*;

  localparam int SlotW = $clog2(THREAD_SLOTS);

  slot_entry_t             mem_q [THREAD_SLOTS];
  slot_entry_t             rd_data_q;
  logic [THREAD_SLOTS-1:0] vld_q;
  logic                    boot_q;
  logic                    rd_vld_q;
  logic                    rd_run_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_ent_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // boot_q: an unwritten slot 0 reads as running with one quantum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      boot_q   <= 1'b1;
      rd_vld_q <= 1'b0;
      rd_run_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q  <= '0;
        boot_q <= clr_boot_i;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        rd_run_q <= boot_q && (rd_addr_i == SlotW'(0));
      end
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      rd_ent_o = rd_data_q;
    end else if (rd_run_q) begin
      rd_ent_o = '{state: SLOT_RUNNING, quanta: QuantaW'(1)};
    end else begin
      rd_ent_o = '{state: SLOT_UNUSED, quanta: '0};
    end
  end

endmodule

// ===== verif/tb_round_robin_thread_scheduler.sv =====
// testbench for the round-robin thread scheduler: directed and random events against a scoreboard
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int NumSlots = 16;

  class sched_scoreboard;
    slot_state_e       st[NumSlots];
    logic [QuantaW-1:0] quanta[NumSlots];
    logic [TidW-1:0]   cur;
    logic [QuantaW-1:0] ticks;
    out_item_t         expected_q[$];
    int                fail_count;
    int                results_seen;

    function new();
      fail_count   = 0;
      results_seen = 0;
      start_up();
    endfunction

    function void clear_table();
      foreach (st[i]) begin
        st[i]     = SLOT_UNUSED;
        quanta[i] = '0;
      end
      cur = '0;
    endfunction

    function void start_up();
      clear_table();
      st[0]     = SLOT_RUNNING;
      quanta[0] = 1;
      ticks     = 1;
    endfunction

    // next ready slot after the current one takes the processor
    function bit hand_over();
      int s;
      for (int k = 1; k < NumSlots; k++) begin
        s = (int'(cur) + k) % NumSlots;
        if (st[s] == SLOT_READY) begin
          st[s] = SLOT_RUNNING;
          cur   = TidW'(s);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t       r;
      logic [TidW-1:0] prev;
      logic [TidW-1:0] t;
      bit              known;
      bit              was_running;
      bit              moved;
      r        = '0;
      r.status = STS_OK;
      prev     = cur;
      t        = ev.thread_id;
      known    = (st[t] != SLOT_UNUSED);
      case (ev.opcode)
        OP_INIT: start_up();
        OP_SPAWN: begin
          if (!ev.entry_present) begin
            r.status = STS_NULL_ENTRY;
          end else begin
            r.status = STS_FULL;
            for (int k = 0; k < NumSlots; k++) begin
              if (st[k] == SLOT_UNUSED) begin
                st[k]          = SLOT_READY;
                quanta[k]      = '0;
                r.result_value = k;
                r.status       = STS_OK;
                break;
              end
            end
          end
        end
        OP_TERM: begin
          if (!known) begin
            r.status = STS_NO_THREAD;
          end else if (t == 0) begin
            clear_table();
            r.process_end = 1'b1;
          end else begin
            st[t]     = SLOT_UNUSED;
            quanta[t] = '0;
            if (t == cur) moved = hand_over();
          end
        end
        OP_BLOCK: begin
          if (!known) r.status = STS_NO_THREAD;
          else if (t == 0) r.status = STS_MAIN;
          else st[t] = SLOT_BLOCKED;
        end
        OP_RESUME: begin
          if (!known) r.status = STS_NO_THREAD;
          else if (st[t] == SLOT_BLOCKED) st[t] = SLOT_READY;
        end
        OP_SLEEP: begin
          if (cur == 0) r.status = STS_MAIN;
          else if (st[cur] == SLOT_UNUSED) r.status = STS_NO_THREAD;
          else st[cur] = SLOT_BLOCKED;
        end
        OP_TICK: begin
          was_running = (st[prev] == SLOT_RUNNING);
          ticks       = ticks + 1;
          quanta[prev] = quanta[prev] + 1;
          if (was_running) st[prev] = SLOT_READY;
          moved = hand_over();
          // a lone running thread keeps the processor
          if (!moved && was_running) st[prev] = SLOT_RUNNING;
        end
        OP_QUERY: begin
          if (!known) begin
            r.status = STS_NO_THREAD;
          end else begin
            r.result_value = quanta[t];
            if (st[t] == SLOT_RUNNING) r.result_value = quanta[t] + 1;
          end
        end
        default: ;
      endcase
      r.running_thread = cur;
      r.tick_total     = ticks;
      r.switched       = (cur != prev);
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // mostly aim at slots that hold a thread
    function logic [TidW-1:0] pick_live();
      logic [TidW-1:0] live_q[$];
      foreach (st[i]) if (st[i] != SLOT_UNUSED) live_q.push_back(TidW'(i));
      if (live_q.size() == 0) return TidW'($urandom_range(0, NumSlots - 1));
      return live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d, %s: got %0h expected %0h",
               results_seen, field, got, want);
      fail_count++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", got.tick_total, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.result_value !== want.result_value)
        report_mismatch("result_value", got.result_value, want.result_value);
      if (got.running_thread !== want.running_thread)
        report_mismatch("running_thread", 32'(got.running_thread),
                        32'(want.running_thread));
      if (got.tick_total !== want.tick_total)
        report_mismatch("tick_total", got.tick_total, want.tick_total);
      if (got.switched !== want.switched)
        report_mismatch("switched", 32'(got.switched), 32'(want.switched));
      if (got.process_end !== want.process_end)
        report_mismatch("process_end", 32'(got.process_end), 32'(want.process_end));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  sched_scoreboard sched = new();
  int  sent_count = 0;
  bit  calm = 1'b0;
  bit  pressure_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  round_robin_thread_scheduler #(
    .THREAD_SLOTS(NumSlots)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic in_item_t ev_of(opcode_e op, logic [TidW-1:0] tid, logic entry);
    in_item_t ev;
    ev.opcode        = op;
    ev.thread_id     = tid;
    ev.entry_present = entry;
    return ev;
  endfunction

  function automatic in_item_t random_event();
    in_item_t ev;
    int       roll;
    ev.thread_id     = TidW'($urandom_range(0, NumSlots - 1));
    ev.entry_present = ($urandom_range(0, 9) != 0);
    roll = $urandom_range(0, 99);
    if (roll < 22) ev.opcode = OP_TICK;
    else if (roll < 40) ev.opcode = OP_SPAWN;
    else if (roll < 52) ev.opcode = OP_QUERY;
    else if (roll < 62) ev.opcode = OP_BLOCK;
    else if (roll < 74) ev.opcode = OP_RESUME;
    else if (roll < 83) ev.opcode = OP_TERM;
    else if (roll < 92) ev.opcode = OP_SLEEP;
    else if (roll < 94) ev.opcode = OP_INIT;
    else ev.opcode = opcode_e'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) ev.thread_id = sched.pick_live();
    return ev;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_event(input in_item_t ev);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sched.note_event(ev);
    sent_count++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sched.check_result(out_item);
  end

  // receiver side stall pattern, with one long hold-off to back the block up
  initial begin
    int n;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!pressure_done && sent_count >= 400) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        n = 400;
      end else if (calm || $urandom_range(0, 1)) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 6);
      end else begin
        out_stall <= 1'b1;
        n = idle_len();
        if (n == 0) n = 1;
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_event(ev_of(OP_QUERY, 4'd0, 1'b0));
    send_event(ev_of(OP_SPAWN, 4'd0, 1'b0));
    send_event(ev_of(OP_SPAWN, 4'd0, 1'b1));
    send_event(ev_of(OP_QUERY, 4'd15, 1'b1));
    send_event(ev_of(OP_BLOCK, 4'd0, 1'b0));
    send_event(ev_of(OP_SLEEP, 4'd0, 1'b0));
    send_event(ev_of(OP_RESUME, 4'd1, 1'b0));
    send_event(ev_of(OP_RESUME, 4'd0, 1'b0));
    send_event(ev_of(OP_TICK, 4'd0, 1'b0));
    send_event(ev_of(OP_QUERY, 4'd1, 1'b0));
    send_event(ev_of(OP_SLEEP, 4'd0, 1'b0));
    // blocked current thread gives way on the tick
    send_event(ev_of(OP_TICK, 4'd0, 1'b0));
    send_event(ev_of(OP_RESUME, 4'd1, 1'b0));
    send_event(ev_of(OP_SPAWN, 4'd0, 1'b1));
    send_event(ev_of(OP_BLOCK, 4'd2, 1'b0));
    send_event(ev_of(OP_TICK, 4'd0, 1'b0));
    send_event(ev_of(OP_TERM, 4'd1, 1'b0));
    send_event(ev_of(OP_TERM, 4'd2, 1'b0));
    send_event(ev_of(OP_TERM, 4'd0, 1'b0));
    send_event(ev_of(OP_TICK, 4'd0, 1'b0));
    send_event(ev_of(OP_SPAWN, 4'd0, 1'b1));
    send_event(ev_of(OP_SLEEP, 4'd0, 1'b0));
    send_event(ev_of(OP_INIT, 4'd0, 1'b0));
    send_event(ev_of(OP_TERM, 4'd9, 1'b1));

    while (sent_count < 1524) begin
      calm = (sent_count >= 700 && sent_count < 900);
      if ($urandom_range(0, 59) == 0) begin
        // spawn burst runs the table full
        repeat (17) send_event(ev_of(OP_SPAWN, TidW'($urandom_range(0, NumSlots - 1)), 1'b1));
      end else begin
        send_event(random_event());
      end
    end

    in_valid <= 1'b0;
    while (sched.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sched.fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
